@@ sv/mme_pkg.sv @@
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types and constants of the matrix multiply engine: field widths,
// operation and register codes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mme_pkg;

	// field and storage widths
	localparam int ELEM_W      = 16;
	localparam int PROD_W      = 2 * ELEM_W;
	localparam int ACC_W       = 40;
	localparam int STORE_AW    = 12;
	localparam int STORE_DEPTH = 1 << STORE_AW;
	localparam int DIM_W       = 7;
	localparam int ROW_W       = 6;
	localparam int ROW_LIMIT   = 1 << ROW_W;
	localparam int OP_W        = 2;
	localparam int CFG_IDX_W   = 2;

	// stream payload widths, padded to whole bytes
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 48;

	// default dimension clamp
	localparam int MAX_DIM_DEFAULT = 64;

	// reset value of the dimension registers
	localparam logic [DIM_W-1:0] DIM_RESET = 7'd4;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE_A = 2'd0,
		OP_WRITE_B = 2'd1,
		OP_COMPUTE = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROWS_A    = 2'd0,
		CFG_COLS_B    = 2'd1,
		CFG_INNER_DIM = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_RUN,
		ST_DRAIN,
		ST_PUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic                a_we;
		logic                b_we;
		logic                rd_en;
		logic                first;
		logic [STORE_AW-1:0] a_addr;
		logic [STORE_AW-1:0] b_addr;
		logic                out_load;
		logic [ROW_W-1:0]    out_row;
		logic                out_last;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} stat_t;

endpackage

@@ sv/mme_ram.sv @@
// ----------------------------------------------------------------------------
// mme_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mme_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/mme_datapath.sv @@
// ----------------------------------------------------------------------------
// mme_datapath
// Operand stores, the shared multiply-accumulate pipe and the output
// register of the matrix multiply engine.
// ----------------------------------------------------------------------------
module mme_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mme_pkg::cmd_t                      cmd,
	output mme_pkg::stat_t                     stat,
	input  logic [mme_pkg::STORE_AW-1:0]       wr_addr,
	input  logic [mme_pkg::ELEM_W-1:0]         wr_data,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [mme_pkg::ACC_W-1:0]          out_value,
	output logic [mme_pkg::ROW_W-1:0]          out_row,
	output logic                               out_last
);

	logic [mme_pkg::ELEM_W-1:0]  a_rd;
	logic [mme_pkg::ELEM_W-1:0]  b_rd;
	logic                        valid_s1;
	logic                        first_s1;
	logic                        valid_s2;
	logic                        first_s2;
	logic signed [mme_pkg::PROD_W-1:0] prod_s2;
	logic [mme_pkg::ACC_W-1:0]   acc_q;
	logic [mme_pkg::ACC_W-1:0]   acc_base;
	logic [mme_pkg::ACC_W-1:0]   prod_ext;
	logic                        out_valid_q;
	logic [mme_pkg::ACC_W-1:0]   out_value_q;
	logic [mme_pkg::ROW_W-1:0]   out_row_q;
	logic                        out_last_q;

	// operand stores
	mme_ram #(
		.WIDTH (mme_pkg::ELEM_W),
		.DEPTH (mme_pkg::STORE_DEPTH)
	) u_a_store (
		.clk   (clk),
		.we    (cmd.a_we),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (cmd.rd_en),
		.raddr (cmd.a_addr),
		.rdata (a_rd)
	);

	mme_ram #(
		.WIDTH (mme_pkg::ELEM_W),
		.DEPTH (mme_pkg::STORE_DEPTH)
	) u_b_store (
		.clk   (clk),
		.we    (cmd.b_we),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (cmd.rd_en),
		.raddr (cmd.b_addr),
		.rdata (b_rd)
	);

	// pipe valid flags: read data, then product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_en;
			valid_s2 <= valid_s1;
		end
	end

	// first-term flags and the product register
	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		first_s2 <= first_s1;
		prod_s2  <= $signed(a_rd) * $signed(b_rd);
	end

	// accumulate, restarting on the first term of a row
	assign acc_base = first_s2 ? '0 : acc_q;
	assign prod_ext = {{(mme_pkg::ACC_W - mme_pkg::PROD_W){prod_s2[mme_pkg::PROD_W-1]}},
		prod_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_base + prod_ext;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_value_q <= acc_q;
			out_row_q   <= cmd.out_row;
			out_last_q  <= cmd.out_last;
		end
	end

	assign stat.pipe_busy = valid_s1 | valid_s2;
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_row   = out_row_q;
	assign out_last  = out_last_q;

endmodule

@@ sv/mme_ctrl.sv @@
// ----------------------------------------------------------------------------
// mme_ctrl
// Controller of the matrix multiply engine: dimension registers, input
// decode and the row and inner-term sequencer for one column of C.
// ----------------------------------------------------------------------------
module mme_ctrl #(
	parameter int MAX_DIM = mme_pkg::MAX_DIM_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mme_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mme_pkg::DIM_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [mme_pkg::OP_W-1:0]       in_op,
	input  logic [mme_pkg::STORE_AW-1:0]   in_index,
	output mme_pkg::cmd_t                  cmd,
	input  mme_pkg::stat_t                 stat
);

	mme_pkg::state_t state_q;
	mme_pkg::state_t state_nxt;

	logic [mme_pkg::DIM_W-1:0]    rows_q;
	logic [mme_pkg::DIM_W-1:0]    cols_q;
	logic [mme_pkg::DIM_W-1:0]    inner_q;
	logic [mme_pkg::STORE_AW-1:0] col_q;
	logic [mme_pkg::STORE_AW-1:0] b_base_q;
	logic [mme_pkg::STORE_AW-1:0] a_addr_q;
	logic [mme_pkg::STORE_AW-1:0] b_addr_q;
	logic [mme_pkg::DIM_W-1:0]    t_q;
	logic [mme_pkg::ROW_W-1:0]    row_q;

	logic [mme_pkg::DIM_W-1:0]    n_a;
	logic [mme_pkg::DIM_W-1:0]    n_rows;
	logic [mme_pkg::DIM_W-1:0]    m_cols;
	logic [mme_pkg::DIM_W-1:0]    k_dim;
	logic [mme_pkg::DIM_W+mme_pkg::STORE_AW-1:0] b_base_full;
	logic                         accept;
	logic                         col_ok;
	logic                         t_last;
	logic                         row_last;
	mme_pkg::op_t                 op;

	function automatic logic [mme_pkg::DIM_W-1:0] clamp_dim(
		input logic [mme_pkg::DIM_W-1:0] v
	);
		logic [mme_pkg::DIM_W-1:0] r;
		if (v == '0) begin
			r = mme_pkg::DIM_W'(1);
		end else if (int'(v) > MAX_DIM) begin
			r = mme_pkg::DIM_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// effective dimensions
	assign n_a    = clamp_dim(rows_q);
	assign n_rows = (int'(n_a) > mme_pkg::ROW_LIMIT) ? mme_pkg::DIM_W'(mme_pkg::ROW_LIMIT)
		: n_a;
	assign m_cols = clamp_dim(cols_q);
	assign k_dim  = clamp_dim(inner_q);

	assign op       = mme_pkg::op_t'(in_op);
	assign accept   = in_valid && in_ready;
	assign col_ok   = in_index < {{(mme_pkg::STORE_AW - mme_pkg::DIM_W){1'b0}}, m_cols};
	assign t_last   = (t_q == k_dim - mme_pkg::DIM_W'(1));
	assign row_last = ({1'b0, row_q} == n_rows - mme_pkg::DIM_W'(1));

	assign b_base_full = {{mme_pkg::STORE_AW{1'b0}}, k_dim}
		* {{mme_pkg::DIM_W{1'b0}}, col_q};

	// dimension registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= mme_pkg::DIM_RESET;
			cols_q  <= mme_pkg::DIM_RESET;
			inner_q <= mme_pkg::DIM_RESET;
		end else if (cfg_we) begin
			case (mme_pkg::cfg_idx_t'(cfg_index))
				mme_pkg::CFG_ROWS_A:    rows_q  <= cfg_data;
				mme_pkg::CFG_COLS_B:    cols_q  <= cfg_data;
				mme_pkg::CFG_INNER_DIM: inner_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			mme_pkg::ST_IDLE: begin
				if (accept && op == mme_pkg::OP_COMPUTE && col_ok) begin
					state_nxt = mme_pkg::ST_SETUP;
				end
			end
			mme_pkg::ST_SETUP: state_nxt = mme_pkg::ST_RUN;
			mme_pkg::ST_RUN: begin
				if (t_last) begin
					state_nxt = mme_pkg::ST_DRAIN;
				end
			end
			mme_pkg::ST_DRAIN: begin
				if (!stat.pipe_busy) begin
					state_nxt = mme_pkg::ST_PUT;
				end
			end
			mme_pkg::ST_PUT: begin
				if (stat.out_free) begin
					state_nxt = row_last ? mme_pkg::ST_IDLE : mme_pkg::ST_RUN;
				end
			end
			default: state_nxt = mme_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mme_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// sequencer counters and store addresses
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q   <= '0;
			row_q <= '0;
		end else begin
			case (state_q)
				mme_pkg::ST_SETUP: begin
					t_q   <= '0;
					row_q <= '0;
				end
				mme_pkg::ST_RUN: begin
					t_q <= t_q + mme_pkg::DIM_W'(1);
				end
				mme_pkg::ST_PUT: begin
					if (stat.out_free) begin
						t_q   <= '0;
						row_q <= row_q + mme_pkg::ROW_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mme_pkg::ST_IDLE: begin
				col_q <= in_index;
			end
			mme_pkg::ST_SETUP: begin
				b_base_q <= b_base_full[mme_pkg::STORE_AW-1:0];
				b_addr_q <= b_base_full[mme_pkg::STORE_AW-1:0];
				a_addr_q <= '0;
			end
			mme_pkg::ST_RUN: begin
				a_addr_q <= a_addr_q + {{(mme_pkg::STORE_AW - mme_pkg::DIM_W){1'b0}}, n_a};
				b_addr_q <= b_addr_q + mme_pkg::STORE_AW'(1);
			end
			mme_pkg::ST_PUT: begin
				a_addr_q <= {{(mme_pkg::STORE_AW - mme_pkg::ROW_W){1'b0}}, row_q}
					+ mme_pkg::STORE_AW'(1);
				b_addr_q <= b_base_q;
			end
			default: ;
		endcase
	end

	// outputs
	always_comb begin
		in_ready     = (state_q == mme_pkg::ST_IDLE);
		cmd.a_we     = accept && op == mme_pkg::OP_WRITE_A;
		cmd.b_we     = accept && op == mme_pkg::OP_WRITE_B;
		cmd.rd_en    = (state_q == mme_pkg::ST_RUN);
		cmd.first    = (t_q == '0);
		cmd.a_addr   = a_addr_q;
		cmd.b_addr   = b_addr_q;
		cmd.out_load = (state_q == mme_pkg::ST_PUT) && stat.out_free;
		cmd.out_row  = row_q;
		cmd.out_last = row_last;
	end

`ifndef SYNTHESIS
	// a result is only loaded when the output register can take it
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("result loaded over a pending output beat");

	// the sum is only handed over once the mac pipe has drained
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mme_pkg::ST_PUT) |-> !stat.pipe_busy)
		else $error("result taken while mac pipe busy");

	// inner-term counter stays within the inner dimension
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mme_pkg::ST_RUN) |-> (t_q < k_dim))
		else $error("inner-term counter overran");

	// no read is issued outside the run state once the row is done
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mme_pkg::ST_RUN && t_last) |=> !cmd.rd_en)
		else $error("read issued past the last inner term");
`endif

endmodule

@@ sv/matrix_multiply_engine_core.sv @@
// Loads (write A or write B) are accepted back to back while the engine is idle.
// A column request runs the inner terms of each row at one multiply-accumulate per cycle on
// the single shared MAC, which reads one entry from each operand store per cycle; after the
// last term of a row it drains the read and multiply stages and then hands the sum to the
// output register, waiting while that register still holds an unaccepted result.
// Reset (arst_n low) clears control state and sets all dimensions to 4; stores keep contents.
// ----------------------------------------------------------------------------
// matrix_multiply_engine_core
// Column-major GEMM engine on signed Q4.12 elements: element loads into the
// A and B stores, and column requests that stream out one exact Q16.24 dot
// product per row of the requested column of C.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_core #(
	parameter int MAX_DIM = mme_pkg::MAX_DIM_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [mme_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mme_pkg::DIM_W-1:0]         cfg_data,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [mme_pkg::IN_TDATA_W-1:0]    s_tdata,  // element_index, element_value, pad
	input  logic [mme_pkg::OP_W-1:0]          s_tuser,  // operation
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mme_pkg::OUT_TDATA_W-1:0]   m_tdata,  // product_value, row_number, pad
	output logic                              m_tlast   // last_of_column
);

	mme_pkg::cmd_t  cmd;
	mme_pkg::stat_t stat;

	logic [mme_pkg::STORE_AW-1:0] in_index;
	logic [mme_pkg::ELEM_W-1:0]   in_value;
	logic [mme_pkg::ACC_W-1:0]    out_value;
	logic [mme_pkg::ROW_W-1:0]    out_row;

	// unpack the input beat
	assign in_index = s_tdata[mme_pkg::STORE_AW-1:0];
	assign in_value = s_tdata[mme_pkg::STORE_AW+mme_pkg::ELEM_W-1:mme_pkg::STORE_AW];

	mme_ctrl #(
		.MAX_DIM (MAX_DIM)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser),
		.in_index  (in_index),
		.cmd       (cmd),
		.stat      (stat)
	);

	mme_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.wr_addr   (in_index),
		.wr_data   (in_value),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_value (out_value),
		.out_row   (out_row),
		.out_last  (m_tlast)
	);

	// pack the result beat
	assign m_tdata = {{(mme_pkg::OUT_TDATA_W - mme_pkg::ACC_W - mme_pkg::ROW_W){1'b0}},
		out_row, out_value};

endmodule
